/* design/see_pkg.sv */
// ----------------------------------------------------------------------------
// see_pkg
// Shared types, codes and character helpers for the stack expression
// evaluator.
// ----------------------------------------------------------------------------
package see_pkg;

    localparam int VALUE_W = 32;

    // ASCII codes of the characters the evaluator understands.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [VALUE_W-1:0] VALUE_NONE = '1;

    // Operator codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes, also used for the latched error code.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Character classes.
    localparam logic [1:0] CLS_DIGIT = 2'd0;
    localparam logic [1:0] CLS_OP    = 2'd1;
    localparam logic [1:0] CLS_BAD   = 2'd2;

    typedef struct packed {
        logic       push_digit;
        logic       push_res;
        logic       pop;
        logic       cap_first;
        logic       cap_second;
        logic       exec;
        logic       set_invalid;
        logic       out_load;
        logic       op_load;
    } see_cmd_t;

    typedef struct packed {
        logic [1:0] err_code;
        logic [1:0] op;
        logic       div_zero;
        logic       div_done;
    } see_status_t;

    function automatic logic [1:0] char_class(input logic [7:0] ch);
        logic [1:0] cls;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
            cls = CLS_OP;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

    function automatic logic [1:0] char_op(input logic [7:0] ch);
        logic [1:0] op;
        case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

endpackage

/* design/see_divider.sv */
// ----------------------------------------------------------------------------
// see_divider
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module see_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes; the sign is applied at the output.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg <= divisor[31] ? (32'd0 - divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

/* design/see_datapath.sv */
// ----------------------------------------------------------------------------
// see_datapath
// Operand stack memory, stack pointer, error code, ALU, divider and the
// result payload register.
// ----------------------------------------------------------------------------
module see_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  see_pkg::see_cmd_t     cmd,
    output see_pkg::see_status_t  status,
    input  logic [7:0]            s_ch,
    input  logic                  cfg_valid,
    input  logic                  cfg_data,
    output logic [31:0]           m_value,
    output logic [1:0]            m_status
);
    import see_pkg::*;

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [VALUE_W-1:0] mem [STACK_DEPTH];

    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [1:0]         err_reg, err_next;
    logic               mode_reg;
    logic [1:0]         op_reg;
    logic [VALUE_W-1:0] rdata_reg;
    logic               empty_reg;
    logic [VALUE_W-1:0] first_reg;
    logic [VALUE_W-1:0] second_reg;
    logic [VALUE_W-1:0] res_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [1:0]         stat_reg;

    logic               full;
    logic               wen;
    logic [VALUE_W-1:0] wdata;
    logic [SP_W-1:0]    sp_m1;
    logic [VALUE_W-1:0] popped;
    logic [VALUE_W-1:0] left, right;
    logic               div_done;
    logic [VALUE_W-1:0] div_quot;
    logic               div_start;

    assign full   = (sp_reg >= SP_W'(STACK_DEPTH));
    assign sp_m1  = sp_reg - SP_W'(1);
    assign popped = empty_reg ? VALUE_NONE : rdata_reg;
    assign left   = mode_reg ? first_reg : second_reg;
    assign right  = mode_reg ? second_reg : first_reg;
    assign wen    = (cmd.push_digit || cmd.push_res) && !full;
    assign wdata  = cmd.push_digit ? VALUE_W'(s_ch - CH_ZERO) : res_reg;
    assign div_start = cmd.exec && (op_reg == OP_DIV) && (right != '0);

    always_comb begin
        sp_next  = sp_reg;
        err_next = err_reg;
        if (cmd.push_digit || cmd.push_res) begin
            if (!full) begin
                sp_next = sp_reg + SP_W'(1);
            end else if (err_reg == ST_OK) begin
                err_next = ST_OVERFLOW;
            end
        end
        if (cmd.pop && sp_reg != '0) begin
            sp_next = sp_m1;
        end
        if (cmd.set_invalid) begin
            err_next = ST_INVALID;
        end
        if (cmd.exec && op_reg == OP_DIV && right == '0 && err_reg == ST_OK) begin
            err_next = ST_DIV_ZERO;
        end
        if (cmd.out_load) begin
            sp_next  = '0;
            err_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg   <= '0;
            err_reg  <= ST_OK;
            mode_reg <= 1'b0;
        end else begin
            sp_reg  <= sp_next;
            err_reg <= err_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
        end
    end

    // Stack memory: one write port at the pointer, one registered read port
    // at the entry below it.
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[sp_reg[ADDR_W-1:0]] <= wdata;
        end
        if (cmd.pop) begin
            rdata_reg <= mem[sp_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            empty_reg <= (sp_reg == '0);
        end
        if (cmd.op_load) begin
            op_reg <= char_op(s_ch);
        end
        if (cmd.cap_first) begin
            first_reg <= popped;
        end
        if (cmd.cap_second) begin
            second_reg <= popped;
        end
        if (cmd.exec) begin
            case (op_reg)
                OP_ADD:  res_reg <= left + right;
                OP_SUB:  res_reg <= left - right;
                OP_MUL:  res_reg <= left * right;
                default: res_reg <= VALUE_NONE;
            endcase
        end else if (div_done) begin
            res_reg <= div_quot;
        end
        if (cmd.out_load) begin
            value_reg <= (err_reg == ST_INVALID) ? VALUE_NONE : popped;
            stat_reg  <= err_reg;
        end
    end

    see_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (left),
        .divisor  (right),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign status.err_code = err_reg;
    assign status.op       = op_reg;
    assign status.div_zero = (right == '0);
    assign status.div_done = div_done;

    assign m_value  = value_reg;
    assign m_status = stat_reg;

endmodule

/* design/see_controller.sv */
// ----------------------------------------------------------------------------
// see_controller
// Sequencer that steps each item through pops, execution, push and output.
// ----------------------------------------------------------------------------
module see_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [7:0]           s_ch,
    output logic                 m_valid,
    input  logic                 m_ready,
    output see_pkg::see_cmd_t    cmd,
    input  see_pkg::see_status_t status
);
    import see_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POP1   = 4'd1;
    localparam logic [3:0] S_POP2   = 4'd2;
    localparam logic [3:0] S_CAP2   = 4'd3;
    localparam logic [3:0] S_EXEC   = 4'd4;
    localparam logic [3:0] S_DIVW   = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_ENDRD  = 4'd7;
    localparam logic [3:0] S_ENDOUT = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       accept;
    logic [1:0] cls;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign cls     = char_class(s_ch);

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_kind) begin
                        state_next = S_ENDRD;
                    end else if (status.err_code != ST_INVALID) begin
                        case (cls)
                            CLS_DIGIT: cmd.push_digit = 1'b1;
                            CLS_OP: begin
                                cmd.op_load = 1'b1;
                                state_next  = S_POP1;
                            end
                            default: cmd.set_invalid = 1'b1;
                        endcase
                    end
                end
            end
            S_POP1: begin
                cmd.pop    = 1'b1;
                state_next = S_POP2;
            end
            S_POP2: begin
                cmd.cap_first = 1'b1;
                cmd.pop       = 1'b1;
                state_next    = S_CAP2;
            end
            S_CAP2: begin
                cmd.cap_second = 1'b1;
                state_next     = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (status.op == OP_DIV && !status.div_zero) begin
                    state_next = S_DIVW;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_DIVW: begin
                if (status.div_done) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.push_res = 1'b1;
                state_next   = S_IDLE;
            end
            S_ENDRD: begin
                cmd.pop    = 1'b1;
                state_next = S_ENDOUT;
            end
            S_ENDOUT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_ready))
        else $error("result loaded over an untaken result");

    a_end_goes_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind) |=> (state_reg == S_ENDRD))
        else $error("end item did not start the final pop");

    a_div_wait_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVW && !status.div_done) |=> (state_reg == S_DIVW))
        else $error("left divide wait before the quotient was ready");

    a_result_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> mvalid_reg)
        else $error("loaded result not presented");

endmodule

/* design/stack_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// stack_expression_evaluator_core
// Single-digit integer expression evaluator on an operand stack, postfix or
// prefix order.
// ----------------------------------------------------------------------------
// One item is taken at a time. A digit, an ignored character or an invalid
// character is handled as it is accepted. An operator steps through two pops
// through the registered stack memory read port, execute and push; a division
// also waits for the divider, which retires one quotient bit per cycle, and a
// division by zero skips the divider. An end item does a final pop and
// produces one result, which waits in an output register while the next item
// is accepted; a second end item waits until the earlier result has been
// taken. The stack memory needs no clearing pass: only entries below the
// stack pointer are ever used.
module stack_expression_evaluator_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_ch,
    // Result items.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [1:0]  m_status,
    // Order mode register write: 0 postfix, 1 prefix.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import see_pkg::*;

    see_cmd_t    cmd;
    see_status_t status;

    // The mode register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences each item; it never touches data itself.
    see_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_ch    (s_ch),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // The datapath holds the stack, the error code, the arithmetic units and
    // the result payload.
    see_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_ch      (s_ch),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_value   (m_value),
        .m_status  (m_status)
    );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stack expression evaluator core. A clocked
// driver feeds expression characters and end items from a queue, a scoreboard
// model of the operand stack predicts each answer, and a clocked monitor
// compares every answer against the oldest prediction. The run steps through
// postfix and prefix order under several back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_top;

    import see_pkg::*;

    localparam int STACK_DEPTH = 64;

    // Item kinds and order modes as seen on the ports.
    localparam logic KIND_CHAR     = 1'b0;
    localparam logic KIND_END      = 1'b1;
    localparam logic MODE_POSTFIX  = 1'b0;
    localparam logic MODE_PREFIX   = 1'b1;

    // Run shape. The drain wait covers the slowest operator, a division, with
    // margin to spare, since characters produce no answer.
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_BUDGET   = 192;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TIMEOUT_TIME   = 8 * 600000;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } expr_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } answer_t;

    // Clock, reset and all block inputs start at known values.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_kind    = 1'b0;
    logic [7:0]  s_ch      = 8'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [31:0] m_value;
    logic [1:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    stack_expression_evaluator_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_ch      (s_ch),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_status  (m_status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Items waiting to be driven, and answers waiting to be observed.
    expr_item_t char_feed[$];
    answer_t    answers[$];

    int items_queued    = 0;
    int items_accepted  = 0;
    int answers_checked = 0;
    int fail_count      = 0;
    int status_seen[4]  = '{0, 0, 0, 0};

    // Idle percentages of the sender and the receiver for the current phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // ------------------------------------------------------------------
    // Scoreboard model of the evaluator: its own stack, stack level,
    // latched error code and order mode.
    // ------------------------------------------------------------------
    logic [31:0] stack_mem [STACK_DEPTH];
    int unsigned stack_level = 0;
    logic [1:0]  latched_err = ST_OK;
    logic        order_mode  = MODE_POSTFIX;

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic logic is_operator(input logic [7:0] ch);
        return ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH;
    endfunction

    // Only the first error of an expression is kept.
    task automatic note_error(input logic [1:0] code);
        if (latched_err == ST_OK) begin
            latched_err = code;
        end
    endtask

    // An empty stack pops as all ones and stays empty.
    task automatic pop_operand(output logic [31:0] v);
        if (stack_level == 0) begin
            v = VALUE_NONE;
        end else begin
            stack_level = stack_level - 1;
            v = stack_mem[stack_level];
        end
    endtask

    // A push onto a full stack is dropped and flagged as an overflow.
    task automatic push_operand(input logic [31:0] v);
        if (stack_level >= STACK_DEPTH) begin
            note_error(ST_OVERFLOW);
        end else begin
            stack_mem[stack_level] = v;
            stack_level = stack_level + 1;
        end
    endtask

    // Signed division truncating toward zero; a zero divisor gives all ones.
    task automatic divide_operands(input logic [31:0] a, input logic [31:0] b,
                                   output logic [31:0] q);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        if (b == 32'd0) begin
            note_error(ST_DIV_ZERO);
            q = VALUE_NONE;
        end else begin
            mag_a = a[31] ? 32'd0 - a : a;
            mag_b = b[31] ? 32'd0 - b : b;
            q = mag_a / mag_b;
            if (a[31] ^ b[31]) begin
                q = 32'd0 - q;
            end
        end
    endtask

    // Applies one accepted item to the model and queues the answer it causes.
    task automatic evaluate_item(input logic kind, input logic [7:0] ch);
        logic [31:0] first_pop;
        logic [31:0] second_pop;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        answer_t     ans;
        if (kind == KIND_END) begin
            pop_operand(ans.value);
            if (latched_err == ST_INVALID) begin
                ans.value = VALUE_NONE;
            end
            ans.status = latched_err;
            answers.push_back(ans);
            stack_level = 0;
            latched_err = ST_OK;
        end else if (latched_err != ST_INVALID) begin
            if (is_digit(ch)) begin
                push_operand({24'd0, 8'(ch - CH_ZERO)});
            end else if (!is_operator(ch)) begin
                latched_err = ST_INVALID;
            end else begin
                pop_operand(first_pop);
                pop_operand(second_pop);
                // In prefix order the first pop is the left operand.
                if (order_mode == MODE_PREFIX) begin
                    lhs = first_pop;
                    rhs = second_pop;
                end else begin
                    lhs = second_pop;
                    rhs = first_pop;
                end
                case (ch)
                    CH_PLUS:  res = lhs + rhs;
                    CH_MINUS: res = lhs - rhs;
                    CH_STAR:  res = lhs * rhs;
                    default:  divide_operands(lhs, rhs, res);
                endcase
                push_operand(res);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. An item is accepted at an edge where valid and ready were
    // both high; the model is updated right there. A new item is loaded
    // whenever the slot is free and the sender does not idle this cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        expr_item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                evaluate_item(s_kind, s_ch);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (char_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = char_feed.pop_front();
                    s_valid <= 1'b1;
                    s_kind  <= next_item.kind;
                    s_ch    <= next_item.ch;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every accepted answer is checked field by field against the
    // oldest prediction. The receiver stalls at random per the phase.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        answer_t head;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers.size() == 0) begin
                    $error("unexpected answer: value %h, status %0d", m_value, m_status);
                    fail_count++;
                end else begin
                    head = answers.pop_front();
                    if (m_value !== head.value) begin
                        $error("m_value: expected %h, actual %h", head.value, m_value);
                        fail_count++;
                    end
                    if (m_status !== head.status) begin
                        $error("m_status: expected %0d, actual %0d", head.status, m_status);
                        fail_count++;
                    end
                    status_seen[head.status]++;
                    answers_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation. Items are counted toward the phase budget
    // unless they follow an invalid character, which the block ignores.
    // ------------------------------------------------------------------
    int   phase_count   = 0;
    logic expr_poisoned = 1'b0;

    task automatic add_item(input logic kind, input logic [7:0] ch);
        expr_item_t it;
        it.kind = kind;
        it.ch   = ch;
        char_feed.push_back(it);
        items_queued++;
        if (!expr_poisoned) begin
            phase_count++;
        end
        if (kind == KIND_END) begin
            expr_poisoned = 1'b0;
        end else if (!is_digit(ch) && !is_operator(ch)) begin
            expr_poisoned = 1'b1;
        end
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] random_op();
        logic [7:0] op;
        case ($urandom_range(3))
            0:       op = CH_PLUS;
            1:       op = CH_MINUS;
            2:       op = CH_STAR;
            default: op = CH_SLASH;
        endcase
        return op;
    endfunction

    task automatic feed_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_item(KIND_CHAR, s[i]);
        end
    endtask

    // The end item carries a random character, which the block must ignore.
    task automatic add_end();
        add_item(KIND_END, 8'($urandom_range(255)));
    endtask

    // Well-formed expression: operands and operators interleaved so that the
    // stack never runs dry and ends with a single entry. Mostly short, now
    // and then long enough for products to wrap.
    task automatic gen_expression();
        int operands;
        int depth;
        int pushed;
        operands = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
        depth = 0;
        pushed = 0;
        while (pushed < operands || depth > 1) begin
            if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
                add_item(KIND_CHAR, random_digit());
                depth++;
                pushed++;
            end else begin
                add_item(KIND_CHAR, random_op());
                depth--;
            end
        end
        add_end();
    endtask

    // Broken expression: any byte, operators on a shallow stack, leftover
    // operands. Invalid characters and underflow pops live here.
    task automatic gen_broken();
        int len;
        int pick;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                add_item(KIND_CHAR, 8'($urandom_range(255)));
            end else if (pick < 7) begin
                add_item(KIND_CHAR, random_op());
            end else begin
                add_item(KIND_CHAR, random_digit());
            end
        end
        add_end();
    endtask

    // Fills the stack to just below, exactly at, or past its depth.
    task automatic gen_overflow();
        int n;
        n = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 3);
        for (int i = 0; i < n; i++) begin
            add_item(KIND_CHAR, random_digit());
        end
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            add_item(KIND_CHAR, random_op());
        end
        add_end();
    endtask

    // Builds the most negative value by doubling 2 thirty times, builds -1
    // from 0 - 1, and divides the two; the quotient wraps back to the most
    // negative value. Operand order follows the current mode.
    task automatic gen_most_negative_div(input logic mode);
        if (mode == MODE_PREFIX) begin
            feed_string("10-");
        end
        add_item(KIND_CHAR, CH_ZERO + 8'd2);
        for (int i = 0; i < 30; i++) begin
            feed_string("2*");
        end
        if (mode == MODE_POSTFIX) begin
            feed_string("01-");
        end
        add_item(KIND_CHAR, CH_SLASH);
        add_end();
    endtask

    // Waits until every item has been taken and every answer seen, then lets
    // the block finish any operator that produces no answer.
    task automatic wait_for_idle();
        while (items_accepted != items_queued || answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the order mode while the block is idle.
    task automatic write_order_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        order_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run sequence. Phases alternate the order mode and walk through
    // three back-pressure profiles: sender idles less than the receiver,
    // the other way round, and no idling at all.
    // ------------------------------------------------------------------
    initial begin : run_sequence
        logic phase_mode;
        int   pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_for_idle();
            end
            phase_mode = (p == 1 || p == 2 || p == 5) ? MODE_PREFIX : MODE_POSTFIX;
            if (p < 2) begin
                send_idle_pct = 30;
                recv_idle_pct = 82;
            end else if (p < 4) begin
                send_idle_pct = 82;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_order_mode(phase_mode);
            phase_count = 0;

            if (p == 0) begin
                // Every operator in one postfix expression: ((9-3)*4)/2+1.
                feed_string("93-4*2/1+");
                add_item(KIND_END, 8'h00);
                // Division by zero.
                feed_string("50/");
                add_item(KIND_END, 8'hFF);
                // Operator on an empty stack pops two all-ones operands.
                add_item(KIND_CHAR, CH_PLUS);
                add_end();
                // End on an empty stack.
                add_end();
                // Invalid characters at both ends of the byte range; what
                // follows the first one is ignored.
                add_item(KIND_CHAR, CH_ZERO + 8'd3);
                add_item(KIND_CHAR, 8'hFF);
                add_item(KIND_CHAR, 8'h00);
                add_item(KIND_CHAR, CH_ZERO + 8'd4);
                add_end();
            end
            if (p == 0 || p == 2) begin
                gen_most_negative_div(phase_mode);
            end
            if (p == 1 || p == 4) begin
                gen_overflow();
            end

            while (phase_count < PHASE_BUDGET) begin
                pick = $urandom_range(99);
                if (pick < 85) begin
                    gen_expression();
                end else begin
                    gen_broken();
                end
            end
        end

        wait_for_idle();

        $display("Run covered %0d input items and %0d answers over %0d mode phases.",
                 items_accepted, answers_checked, NUM_PHASES);
        $display("Answers by status: %0d ok, %0d invalid, %0d divide by zero, %0d overflow.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Safety net in case the block stops answering or handshaking.
    initial begin : watchdog
        #(TIMEOUT_TIME);
        $display("tb_top: errors");
        $finish;
    end

endmodule
